/* src/fqd_pkg.sv */
// Package for the FIFO queue with delete by value.
// Holds sizes, operation and status codes, and the structs passed between modules.
// Has no dependencies.
`timescale 1ns / 1ps

package fqd_pkg;

  localparam int DEPTH  = 16;
  localparam int ITEM_W = 32;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_ITER = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [ITEM_W-1:0] item;
    logic [CW-1:0]     length;
    logic              last;
  } res_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [AW-1:0]     addr;
    logic [ITEM_W-1:0] wdata;
  } mem_req_t;

endpackage

/* src/fqd_mem.sv */
// Single-port item store for the queue, with registered read data.
// Depends on fqd_pkg.
`timescale 1ns / 1ps

module fqd_mem (
  input  logic                      clk,
  input  fqd_pkg::mem_req_t         req,
  output logic [fqd_pkg::ITEM_W-1:0] rd_data
);
  import fqd_pkg::*;

  logic [ITEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

/* src/fqd_seq.sv */
// Sequencer of the queue: keeps head and count, walks the store for delete
// and iterate, and issues at most one memory access per cycle. Depends on fqd_pkg.
`timescale 1ns / 1ps

module fqd_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_op,
  input  logic [fqd_pkg::ITEM_W-1:0] in_val,
  output fqd_pkg::mem_req_t          mreq,
  input  logic [fqd_pkg::ITEM_W-1:0] rdata,
  output logic                       res_vld,
  input  logic                       res_rdy,
  output fqd_pkg::res_t              res
);
  import fqd_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EMIT   = 4'd1;
  localparam logic [3:0] S_DEQ    = 4'd2;
  localparam logic [3:0] S_SC_RD  = 4'd3;
  localparam logic [3:0] S_SC_CMP = 4'd4;
  localparam logic [3:0] S_SH_RD  = 4'd5;
  localparam logic [3:0] S_SH_WR  = 4'd6;
  localparam logic [3:0] S_IT_RD  = 4'd7;
  localparam logic [3:0] S_IT_EM  = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [ITEM_W-1:0] val_r, val_nxt;
  logic [1:0]        st_r, st_nxt;

  logic [CW-1:0]     lidx;
  logic [CW-1:0]     idx_inc;
  logic [CW:0]       sum;
  logic [AW-1:0]     phys;

  assign idx_inc  = idx_r + CW'(1);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    case (state_r)
      S_IDLE:  lidx = (in_op == OP_ENQ) ? cnt_r : '0;
      S_SH_RD: lidx = idx_inc;
      default: lidx = idx_r;
    endcase
  end

  always_comb begin
    sum = (CW + 1)'(head_r) + (CW + 1)'(lidx);
    if (sum >= (CW + 1)'(DEPTH)) begin
      sum = sum - (CW + 1)'(DEPTH);
    end
    phys = sum[AW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    st_nxt    = st_r;
    mreq      = '0;
    mreq.addr = phys;
    res_vld   = 1'b0;
    res       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EMIT;
          idx_nxt   = '0;
          val_nxt   = in_val;
          case (in_op)
            OP_ENQ: begin
              if (in_val == '0 || cnt_r == CW'(DEPTH)) begin
                st_nxt = ST_REJECT;
              end else begin
                mreq.wr_en = 1'b1;
                mreq.wdata = in_val;
                cnt_nxt    = cnt_r + CW'(1);
                st_nxt     = ST_OK;
              end
            end
            OP_DEQ: begin
              if (cnt_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                mreq.rd_en = 1'b1;
                head_nxt   = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
                cnt_nxt    = cnt_r - CW'(1);
                state_nxt  = S_DEQ;
              end
            end
            OP_DEL: begin
              if (in_val == '0) begin
                st_nxt = ST_REJECT;
              end else if (cnt_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SC_RD;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_IT_RD;
              end
            end
          endcase
        end
      end
      S_EMIT: begin
        res_vld    = 1'b1;
        res.status = st_r;
        res.length = cnt_r;
        res.last   = 1'b1;
        if (res_rdy) begin
          state_nxt = S_IDLE;
        end
      end
      S_DEQ: begin
        res_vld    = 1'b1;
        res.status = ST_OK;
        res.item   = rdata;
        res.length = cnt_r;
        res.last   = 1'b1;
        if (res_rdy) begin
          state_nxt = S_IDLE;
        end
      end
      S_SC_RD: begin
        mreq.rd_en = 1'b1;
        state_nxt  = S_SC_CMP;
      end
      S_SC_CMP: begin
        if (rdata == val_r) begin
          state_nxt = S_SH_RD;
        end else if (idx_inc == cnt_r) begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SC_RD;
        end
      end
      S_SH_RD: begin
        if (idx_inc == cnt_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          st_nxt    = ST_OK;
          state_nxt = S_EMIT;
        end else begin
          mreq.rd_en = 1'b1;
          state_nxt  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        mreq.wr_en = 1'b1;
        mreq.wdata = rdata;
        idx_nxt    = idx_inc;
        state_nxt  = S_SH_RD;
      end
      S_IT_RD: begin
        mreq.rd_en = 1'b1;
        state_nxt  = S_IT_EM;
      end
      S_IT_EM: begin
        res_vld    = 1'b1;
        res.status = ST_OK;
        res.item   = rdata;
        res.length = cnt_r;
        res.last   = (idx_inc == cnt_r);
        if (res_rdy) begin
          if (idx_inc == cnt_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_IT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      st_r    <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* src/fifo_queue_with_delete.sv */
// Top level of the FIFO queue with delete by value.
// Instantiates fqd_seq and fqd_mem and holds the output register; uses fqd_pkg.
//
// The input channel takes one transaction per operation: in_tuser is the
// operation (enqueue, dequeue, delete by value, iterate) and in_tdata the
// item handle. Each operation produces one result transaction on the output
// channel, except iterate on a nonempty queue, which produces one per stored
// item, oldest first. out_tuser carries the status, out_tdata the item and
// the queue length, and out_tlast marks the final result of the operation.
// Enqueue, dequeue and rejected operations go from acceptance straight to
// their result. Delete reads and compares entries from the head until the
// match or the end of the queue; on a match it moves each later entry one
// place toward the head, a read and then a write per entry, to close the
// gap. Iterate reads each stored item in turn and gives its result before
// reading the next. The single-port store does one read or write per cycle.
// in_tready is high only while no operation is in progress. A stalled
// receiver holds the sequencer once the output register is full. Reset
// empties the queue; the store itself is not cleared and needs no sweep.
`timescale 1ns / 1ps

module fifo_queue_with_delete (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // [31:0] item_value
  input  logic [1:0]  in_tuser,  // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // [31:0] item_out, [36:32] length, rest zero
  output logic [1:0]  out_tuser, // [1:0] status
  output logic        out_tlast  // last
);
  import fqd_pkg::*;

  mem_req_t          mreq;
  logic [ITEM_W-1:0] rdata;
  logic              res_vld;
  logic              res_rdy;
  res_t              res;
  logic              out_vld_r;
  res_t              out_res_r;

  fqd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_val   (ITEM_W'(in_tdata)),
    .mreq     (mreq),
    .rdata    (rdata),
    .res_vld  (res_vld),
    .res_rdy  (res_rdy),
    .res      (res)
  );

  fqd_mem u_mem (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rdata)
  );

  assign res_rdy = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_vld && res_rdy) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_rdy) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, 5'(out_res_r.length), 32'(out_res_r.item)};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still ready after an accepted transaction");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[36:32] <= 5'(DEPTH)))
    else $error("reported length exceeds the queue depth");

  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tlast && out_tdata[31:0] == '0))
    else $error("failed operation result is not a single zero-item result");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_EMPTY) |-> (out_tdata[36:32] == '0))
    else $error("empty status with nonzero length");

endmodule
